// ----- sv/ljpe_pkg.sv -----
// ----------------------------------------------------------------------------
// ljpe_pkg
// Types and constants shared by the Lennard-Jones pair energy accumulator.
// ----------------------------------------------------------------------------
package ljpe_pkg;

  localparam int unsigned COORD_W   = 22;
  localparam int unsigned SIGMA_W   = 20;
  localparam int unsigned EPS_W     = 24;
  localparam int unsigned SIG2_W    = 2 * SIGMA_W;
  localparam int unsigned ENERGY_W  = 48;
  localparam int unsigned TOTAL_W   = 64;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned CFG_DAT_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SIGMA = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPS   = 8'd1;

  localparam logic [SIGMA_W-1:0] SIGMA_RST = 20'd13107;
  localparam logic [EPS_W-1:0]   EPS_RST   = 24'd262144;

  localparam logic [63:0] CHAIN_CAP = 64'h4000_0000_0000_0000;
  localparam logic [63:0] E_MAX     = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] M_LIMIT   = E_MAX >> 2;

  // multiply jobs, in sequence order
  localparam logic [2:0] JOB_SQ_X  = 3'd0;
  localparam logic [2:0] JOB_SQ_Y  = 3'd1;
  localparam logic [2:0] JOB_SQ_Z  = 3'd2;
  localparam logic [2:0] JOB_Q2    = 3'd3;
  localparam logic [2:0] JOB_S6    = 3'd4;
  localparam logic [2:0] JOB_S12   = 3'd5;
  localparam logic [2:0] JOB_EPS   = 3'd6;

  localparam logic [2:0] MUL_LAST  = 3'd4;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_STEP,
    OP_STORE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [2:0] job;
    logic [2:0] idx;
  } cmd_t;

  typedef struct packed {
    logic r2_zero;
    logic out_busy;
  } status_t;

endpackage

// ----- sv/ljpe_if.sv -----
// ----------------------------------------------------------------------------
// ljpe interfaces
// Pair input, result output and configuration write channels.
// ----------------------------------------------------------------------------
interface ljpe_in_if;
  logic                          valid;
  logic                          ready;
  logic [ljpe_pkg::COORD_W-1:0]  a_x;
  logic [ljpe_pkg::COORD_W-1:0]  a_y;
  logic [ljpe_pkg::COORD_W-1:0]  a_z;
  logic [ljpe_pkg::COORD_W-1:0]  b_x;
  logic [ljpe_pkg::COORD_W-1:0]  b_y;
  logic [ljpe_pkg::COORD_W-1:0]  b_z;
  logic                          last_pair;

  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, last_pair, input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, last_pair, output ready);
endinterface

interface ljpe_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ljpe_pkg::ENERGY_W-1:0] pair_energy;
  logic signed [ljpe_pkg::TOTAL_W-1:0]  group_total;
  logic                                 saturated;
  logic                                 group_end;

  modport source (output valid, pair_energy, group_total, saturated, group_end, input ready);
  modport sink   (input valid, pair_energy, group_total, saturated, group_end, output ready);
endinterface

interface ljpe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [ljpe_pkg::CFG_IDX_W-1:0]  index;
  logic [ljpe_pkg::CFG_DAT_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/ljpe_ctrl.sv -----
// ----------------------------------------------------------------------------
// ljpe_ctrl
// Sequencer: squares, zero check, restoring divide, power chain, finish.
// ----------------------------------------------------------------------------
module ljpe_ctrl #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ljpe_pkg::status_t  status_i,
  output ljpe_pkg::cmd_t     cmd_o
);

  localparam int unsigned DIV_STEPS = ljpe_pkg::SIG2_W + FRAC_BITS;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_STORE = 3'd2;
  localparam logic [2:0] S_ZCHK  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [2:0]       job_q, job_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      job_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
      cnt_q   <= cnt_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    job_d      = job_q;
    cnt_d      = cnt_q;
    cmd_o.op   = ljpe_pkg::OP_NONE;
    cmd_o.job  = job_q;
    cmd_o.idx  = cnt_q[2:0];
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = ljpe_pkg::OP_LOAD;
          job_d    = ljpe_pkg::JOB_SQ_X;
          cnt_d    = '0;
          state_d  = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.op = ljpe_pkg::OP_MUL_STEP;
        if (cnt_q[2:0] == ljpe_pkg::MUL_LAST) begin
          cnt_d   = '0;
          state_d = S_STORE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_STORE: begin
        cmd_o.op = ljpe_pkg::OP_STORE;
        if (job_q == ljpe_pkg::JOB_SQ_Z) begin
          state_d = S_ZCHK;
        end else if (job_q == ljpe_pkg::JOB_EPS) begin
          state_d = S_FIN;
        end else begin
          job_d   = job_q + 1'b1;
          state_d = S_MUL;
        end
      end
      S_ZCHK: begin
        if (status_i.r2_zero) begin
          state_d = S_FIN;
        end else begin
          cmd_o.op = ljpe_pkg::OP_DIV_INIT;
          cnt_d    = '0;
          state_d  = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.op = ljpe_pkg::OP_DIV_STEP;
        if (cnt_q == DIV_LAST) begin
          cnt_d   = '0;
          job_d   = ljpe_pkg::JOB_Q2;
          state_d = S_MUL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_FIN: begin
        if (!status_i.out_busy) begin
          cmd_o.op = ljpe_pkg::OP_FINISH;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/ljpe_dp.sv -----
// ----------------------------------------------------------------------------
// ljpe_dp
// Datapath: shared 32x32 multiplier, restoring divider, accumulator, outputs.
// ----------------------------------------------------------------------------
module ljpe_dp #(
  parameter int unsigned COORD_BITS = 22,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  ljpe_in_if.sink            in_i,
  ljpe_out_if.source         out_o,
  ljpe_cfg_if.sink           cfg_i,
  input  ljpe_pkg::cmd_t     cmd_i,
  output ljpe_pkg::status_t  status_o
);

  localparam int unsigned CW    = ljpe_pkg::COORD_W;
  localparam int unsigned NUM_W = ljpe_pkg::SIG2_W + FRAC_BITS;
  localparam logic [CW-1:0] CMASK =
    (COORD_BITS >= CW) ? {CW{1'b1}} : CW'((64'd1 << COORD_BITS) - 64'd1);

  logic [ljpe_pkg::SIGMA_W-1:0] sigma_q;
  logic [ljpe_pkg::EPS_W-1:0]   eps_q;
  logic signed [63:0]           total_q;

  logic [CW-1:0]   dx_q, dy_q, dz_q;
  logic            last_q;
  logic [63:0]     r2_q;
  logic [63:0]     q_q, q2_q, s6_q, s12_q;
  logic            ov_q;
  logic [NUM_W-1:0] num_q;
  logic [63:0]     rem_q;
  logic [63:0]     pp_q;
  logic [1:0]      sh_q;
  logic [127:0]    acc_q;

  logic                                 out_valid_q;
  logic signed [ljpe_pkg::ENERGY_W-1:0] pe_q;
  logic signed [63:0]                   gt_q;
  logic                                 sat_q, end_q;

  logic [ljpe_pkg::SIG2_W-1:0]          sig2;

  assign cfg_i.ready       = 1'b1;
  assign in_i.ready        = (cmd_i.op == ljpe_pkg::OP_LOAD);

  assign sig2 = {{ljpe_pkg::SIGMA_W{1'b0}}, sigma_q} * {{ljpe_pkg::SIGMA_W{1'b0}}, sigma_q};

  assign status_o.r2_zero  = (r2_q == 64'd0);
  assign status_o.out_busy = out_valid_q && !out_o.ready;

  assign out_o.valid       = out_valid_q;
  assign out_o.pair_energy = pe_q;
  assign out_o.group_total = gt_q;
  assign out_o.saturated   = sat_q;
  assign out_o.group_end   = end_q;

  function automatic logic [CW-1:0] absdiff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    logic [CW-1:0] am, bm;
    am = a & CMASK;
    bm = b & CMASK;
    return (am >= bm) ? (am - bm) : (bm - am);
  endfunction

  // operand select
  logic [63:0] op_a, op_b, sdiff;
  always_comb begin
    sdiff = (s12_q >= s6_q) ? (s12_q - s6_q) : (s6_q - s12_q);
    case (cmd_i.job)
      ljpe_pkg::JOB_SQ_X: begin op_a = 64'(dx_q); op_b = 64'(dx_q); end
      ljpe_pkg::JOB_SQ_Y: begin op_a = 64'(dy_q); op_b = 64'(dy_q); end
      ljpe_pkg::JOB_SQ_Z: begin op_a = 64'(dz_q); op_b = 64'(dz_q); end
      ljpe_pkg::JOB_Q2:   begin op_a = q_q;       op_b = q_q;       end
      ljpe_pkg::JOB_S6:   begin op_a = q2_q;      op_b = q_q;       end
      ljpe_pkg::JOB_S12:  begin op_a = s6_q;      op_b = s6_q;      end
      ljpe_pkg::JOB_EPS:  begin op_a = sdiff;     op_b = 64'(eps_q); end
      default:            begin op_a = '0;        op_b = '0;        end
    endcase
  end

  logic [31:0] part_a, part_b;
  assign part_a = cmd_i.idx[0] ? op_a[63:32] : op_a[31:0];
  assign part_b = cmd_i.idx[1] ? op_b[63:32] : op_b[31:0];

  // fixed-point product result with overflow cap
  logic        mul_ov;
  logic [63:0] mul_val, mul_sh;
  assign mul_ov  = |acc_q[127:64];
  assign mul_sh  = 64'(acc_q[63:FRAC_BITS]);
  assign mul_val = mul_ov ? ljpe_pkg::CHAIN_CAP : mul_sh;

  logic [64:0] r2_sum;
  assign r2_sum = {1'b0, r2_q} + {1'b0, acc_q[63:0]};

  logic [64:0] trial;
  logic        take;
  assign trial = {rem_q, num_q[NUM_W-1]};
  assign take  = (trial >= {1'b0, r2_q});

  // energy and total
  logic signed [63:0] e_val, sum_val;
  logic               e_sat, t_sat;
  logic [64:0]        s65;
  always_comb begin
    e_sat = 1'b0;
    if (status_o.r2_zero || ov_q) begin
      e_val = ljpe_pkg::E_MAX;
      e_sat = 1'b1;
    end else if (s12_q >= s6_q) begin
      if (mul_ov || (mul_sh > ljpe_pkg::M_LIMIT)) begin
        e_val = ljpe_pkg::E_MAX;
        e_sat = 1'b1;
      end else begin
        e_val = mul_sh << 2;
      end
    end else begin
      e_val = -(mul_sh << 2);
    end
    s65   = {total_q[63], total_q} + {e_val[63], e_val};
    t_sat = (s65[64] != s65[63]);
    if (t_sat) begin
      sum_val = e_val[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      sum_val = s65[63:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q     <= ljpe_pkg::SIGMA_RST;
      eps_q       <= ljpe_pkg::EPS_RST;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        if (cfg_i.index == ljpe_pkg::REG_SIGMA) begin
          sigma_q <= cfg_i.data[ljpe_pkg::SIGMA_W-1:0];
        end else if (cfg_i.index == ljpe_pkg::REG_EPS) begin
          eps_q <= cfg_i.data[ljpe_pkg::EPS_W-1:0];
        end
      end
      if (cmd_i.op == ljpe_pkg::OP_FINISH) begin
        out_valid_q <= 1'b1;
        total_q     <= last_q ? 64'sd0 : sum_val;
      end else if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ljpe_pkg::OP_LOAD: begin
        dx_q   <= absdiff(in_i.a_x, in_i.b_x);
        dy_q   <= absdiff(in_i.a_y, in_i.b_y);
        dz_q   <= absdiff(in_i.a_z, in_i.b_z);
        last_q <= in_i.last_pair;
        r2_q   <= '0;
        ov_q   <= 1'b0;
      end
      ljpe_pkg::OP_MUL_STEP: begin
        if (cmd_i.idx != ljpe_pkg::MUL_LAST) begin
          pp_q <= part_a * part_b;
          sh_q <= 2'(cmd_i.idx[0]) + 2'(cmd_i.idx[1]);
        end
        if (cmd_i.idx == 3'd0) begin
          acc_q <= '0;
        end else begin
          acc_q <= acc_q + (128'(pp_q) << {sh_q, 5'b0});
        end
      end
      ljpe_pkg::OP_STORE: begin
        case (cmd_i.job)
          ljpe_pkg::JOB_SQ_X, ljpe_pkg::JOB_SQ_Y, ljpe_pkg::JOB_SQ_Z: begin
            r2_q <= r2_sum[64] ? {64{1'b1}} : r2_sum[63:0];
          end
          ljpe_pkg::JOB_Q2: begin
            q2_q <= mul_val;
            ov_q <= ov_q | mul_ov;
          end
          ljpe_pkg::JOB_S6: begin
            s6_q <= mul_val;
            ov_q <= ov_q | mul_ov;
          end
          ljpe_pkg::JOB_S12: begin
            s12_q <= mul_val;
            ov_q  <= ov_q | mul_ov;
          end
          default: begin
          end
        endcase
      end
      ljpe_pkg::OP_DIV_INIT: begin
        num_q <= {sig2, {FRAC_BITS{1'b0}}};
        rem_q <= '0;
        q_q   <= '0;
      end
      ljpe_pkg::OP_DIV_STEP: begin
        num_q <= num_q << 1;
        rem_q <= take ? 64'(trial - {1'b0, r2_q}) : trial[63:0];
        q_q   <= {q_q[62:0], take};
      end
      ljpe_pkg::OP_FINISH: begin
        pe_q  <= e_val[ljpe_pkg::ENERGY_W-1:0];
        gt_q  <= sum_val;
        sat_q <= e_sat | t_sat;
        end_q <= last_q;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/lj_pair_energy_accumulator_top.sv -----
// ----------------------------------------------------------------------------
// lj_pair_energy_accumulator_top
// Lennard-Jones 12-6 pair energy with a saturating per-group running total.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one word per particle pair (two Q6.16 positions, last_pair flag).
//   out_o : one word per pair: pair energy, group total, saturation, group end.
//   cfg_i : register writes, index 0 sigma, index 1 epsilon; always ready.
// Sequence:
//   A pair runs the squared distance, one zero check, the bit-serial
//   restoring divider, then the power chain and epsilon scaling on the
//   shared 32x32 multiplier (five steps plus a store per product), and a
//   finish step; coincident positions skip from the zero check to finish.
//   in_i is ready only while the controller is idle and in_i.valid is high;
//   a new pair is not taken until the last one has finished.
// Reset:
//   Clears the running total and the output valid flag, and loads the default
//   sigma (0.2) and epsilon (4.0).
// Stall:
//   The result word is held in the output register; the next pair is taken
//   and computed, and waits in its finish step until out_o is free.
// ----------------------------------------------------------------------------
module lj_pair_energy_accumulator_top #(
  parameter int unsigned COORD_BITS = 22,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ljpe_in_if.sink     in_i,
  ljpe_out_if.source  out_o,
  ljpe_cfg_if.sink    cfg_i
);

  ljpe_pkg::cmd_t    cmd;
  ljpe_pkg::status_t status;
  logic              ctrl_ready;

  ljpe_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (ctrl_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ljpe_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .cfg_i    (cfg_i),
    .cmd_i    (cmd),
    .status_o (status)
  );

`ifndef SYNTHESIS
  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.op == ljpe_pkg::OP_LOAD) == (in_i.valid && ctrl_ready))
    else $error("load command without accepted word");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input ready while a pair is in progress");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.op == ljpe_pkg::OP_FINISH))
    else $error("result word without finish step");

  a_ready_matches_ctrl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready == (in_i.valid && ctrl_ready))
    else $error("input ready differs from controller");
`endif

endmodule
